FILE: rtl/ssui_pkg.sv
// shared types and constants for the sorted list union and intersection block
package ssui_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_INS_A  = 2'd0,
        OP_INS_B  = 2'd1,
        OP_UNION  = 2'd2,
        OP_INTER  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ELEMENT = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        logic                     we;
        logic                     sel_b;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

FILE: rtl/sorted_set_union_intersection_top.sv
// top level: sequencer for sorted insert, union and intersection over two lists
// Command port: a word is taken when start is high and busy is low; results come out one
// per strobe, each for a single cycle, and cannot be held off, so the receiver must take
// every strobe. Each command ends with a word that has o_last set. An insert first scans
// for its place and then shifts entries up through the single write port. A union makes
// one shared compare per cycle; an intersection walks all of list b for each entry of
// list a, since every pair goes through the same comparator. A rejected insert answers in
// the cycle after it is taken. No clearing pass after reset.
module sorted_set_union_intersection_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [ssui_pkg::DATA_W-1:0]  i_value,
    output logic                                o_strobe,
    output logic signed [ssui_pkg::DATA_W-1:0]  o_result_value,
    output logic [1:0]                          o_status,
    output logic                                o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_UNION,
        S_INTER
    } t_state;

    t_state                              r_state;
    logic                                r_sel_b;
    logic signed [ssui_pkg::DATA_W-1:0]  r_value;
    logic [ssui_pkg::CNT_W-1:0]          r_cnt_a;
    logic [ssui_pkg::CNT_W-1:0]          r_cnt_b;
    logic [ssui_pkg::CNT_W-1:0]          r_i;
    logic [ssui_pkg::CNT_W-1:0]          r_j;
    logic signed [ssui_pkg::DATA_W-1:0]  r_pend;
    logic                                r_have_pend;

    ssui_pkg::t_wr_req                   wr;
    ssui_pkg::t_cmp                      cmp;
    logic [ssui_pkg::IDX_W-1:0]          raddr_a;
    logic [ssui_pkg::IDX_W-1:0]          raddr_b;
    logic signed [ssui_pkg::DATA_W-1:0]  rdata_a;
    logic signed [ssui_pkg::DATA_W-1:0]  rdata_b;
    logic signed [ssui_pkg::DATA_W-1:0]  rdata_sel;
    logic signed [ssui_pkg::DATA_W-1:0]  cmp_x;
    logic signed [ssui_pkg::DATA_W-1:0]  cmp_y;
    logic [ssui_pkg::CNT_W-1:0]          cnt_sel;
    logic [ssui_pkg::CNT_W-1:0]          shift_src;
    logic                                a_left;
    logic                                b_left;

    // r_i holds the scan position and r_j the shift index during inserts
    assign shift_src = r_j - ssui_pkg::CNT_W'(1);
    assign cnt_sel   = r_sel_b ? r_cnt_b : r_cnt_a;
    assign a_left    = (r_i < r_cnt_a);
    assign b_left    = (r_j < r_cnt_b);

    always_comb begin
        raddr_a = r_i[ssui_pkg::IDX_W-1:0];
        raddr_b = r_j[ssui_pkg::IDX_W-1:0];
        if (r_state == S_SCAN) begin
            raddr_a = r_i[ssui_pkg::IDX_W-1:0];
            raddr_b = r_i[ssui_pkg::IDX_W-1:0];
        end else if (r_state == S_SHIFT) begin
            raddr_a = shift_src[ssui_pkg::IDX_W-1:0];
            raddr_b = shift_src[ssui_pkg::IDX_W-1:0];
        end
    end

    assign rdata_sel = r_sel_b ? rdata_b : rdata_a;
    assign cmp_x     = (r_state == S_SCAN) ? rdata_sel : rdata_a;
    assign cmp_y     = (r_state == S_SCAN) ? r_value : rdata_b;

    always_comb begin
        wr       = '0;
        wr.sel_b = r_sel_b;
        if (r_state == S_SHIFT) begin
            wr.we = 1'b1;
            if (r_j > r_i) begin
                wr.addr = r_j[ssui_pkg::IDX_W-1:0];
                wr.data = rdata_sel;
            end else begin
                wr.addr = r_i[ssui_pkg::IDX_W-1:0];
                wr.data = r_value;
            end
        end
    end

    ssui_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    ssui_cmp u_cmp (
        .i_x   (cmp_x),
        .i_y   (cmp_y),
        .o_res (cmp)
    );

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_have_pend <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_value     <= i_value;
                        r_sel_b     <= (i_operation == ssui_pkg::OP_INS_B);
                        r_i         <= '0;
                        r_j         <= '0;
                        r_have_pend <= 1'b0;
                        unique case (i_operation)
                            ssui_pkg::OP_INS_A, ssui_pkg::OP_INS_B: begin
                                if (((i_operation == ssui_pkg::OP_INS_B) ? r_cnt_b : r_cnt_a)
                                    >= ssui_pkg::CNT_W'(ssui_pkg::CAPACITY)) begin
                                    o_strobe       <= 1'b1;
                                    o_result_value <= '0;
                                    o_status       <= ssui_pkg::ST_FULL;
                                    o_last         <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ssui_pkg::OP_UNION: r_state <= S_UNION;
                            default:            r_state <= S_INTER;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_i < cnt_sel && cmp.lt) begin
                        r_i <= r_i + ssui_pkg::CNT_W'(1);
                    end else begin
                        r_j     <= cnt_sel;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_j > r_i) begin
                        r_j <= shift_src;
                    end else begin
                        if (r_sel_b) begin
                            r_cnt_b <= r_cnt_b + ssui_pkg::CNT_W'(1);
                        end else begin
                            r_cnt_a <= r_cnt_a + ssui_pkg::CNT_W'(1);
                        end
                        o_strobe       <= 1'b1;
                        o_result_value <= '0;
                        o_status       <= ssui_pkg::ST_ACCEPT;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                S_UNION: begin
                    if (a_left || b_left) begin
                        if (a_left && b_left && cmp.eq) begin
                            r_j <= r_j + ssui_pkg::CNT_W'(1);
                        end else begin
                            if (a_left && (!b_left || cmp.lt)) begin
                                r_pend <= rdata_a;
                                r_i    <= r_i + ssui_pkg::CNT_W'(1);
                            end else begin
                                r_pend <= rdata_b;
                                r_j    <= r_j + ssui_pkg::CNT_W'(1);
                            end
                            r_have_pend    <= 1'b1;
                            o_strobe       <= r_have_pend;
                            o_result_value <= r_pend;
                            o_status       <= ssui_pkg::ST_ELEMENT;
                            o_last         <= 1'b0;
                        end
                    end else begin
                        o_strobe       <= 1'b1;
                        o_result_value <= r_have_pend ? r_pend : '0;
                        o_status       <= r_have_pend ? ssui_pkg::ST_ELEMENT
                                                      : ssui_pkg::ST_EMPTY;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                S_INTER: begin
                    if (a_left) begin
                        if (b_left) begin
                            r_j <= r_j + ssui_pkg::CNT_W'(1);
                            if (cmp.eq) begin
                                r_pend         <= rdata_a;
                                r_have_pend    <= 1'b1;
                                o_strobe       <= r_have_pend;
                                o_result_value <= r_pend;
                                o_status       <= ssui_pkg::ST_ELEMENT;
                                o_last         <= 1'b0;
                            end
                        end else begin
                            r_i <= r_i + ssui_pkg::CNT_W'(1);
                            r_j <= '0;
                        end
                    end else begin
                        o_strobe       <= 1'b1;
                        o_result_value <= r_have_pend ? r_pend : '0;
                        o_status       <= r_have_pend ? ssui_pkg::ST_ELEMENT
                                                      : ssui_pkg::ST_EMPTY;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/ssui_store.sv
// register files for list a and list b, one write port shared by both and one read port each
module ssui_store (
    input  logic                                  i_clk,
    input  ssui_pkg::t_wr_req                     i_wr,
    input  logic [ssui_pkg::IDX_W-1:0]            i_raddr_a,
    input  logic [ssui_pkg::IDX_W-1:0]            i_raddr_b,
    output logic signed [ssui_pkg::DATA_W-1:0]    o_rdata_a,
    output logic signed [ssui_pkg::DATA_W-1:0]    o_rdata_b
);

    logic signed [ssui_pkg::DATA_W-1:0] r_list_a [ssui_pkg::CAPACITY];
    logic signed [ssui_pkg::DATA_W-1:0] r_list_b [ssui_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            if (i_wr.sel_b) begin
                r_list_b[i_wr.addr] <= i_wr.data;
            end else begin
                r_list_a[i_wr.addr] <= i_wr.data;
            end
        end
    end

    assign o_rdata_a = r_list_a[i_raddr_a];
    assign o_rdata_b = r_list_b[i_raddr_b];

endmodule

FILE: rtl/ssui_cmp.sv
// shared signed compare unit
module ssui_cmp (
    input  logic signed [ssui_pkg::DATA_W-1:0] i_x,
    input  logic signed [ssui_pkg::DATA_W-1:0] i_y,
    output ssui_pkg::t_cmp                     o_res
);

    assign o_res.lt = (i_x < i_y);
    assign o_res.eq = (i_x == i_y);

endmodule

FILE: sim/sorted_set_union_intersection_top_tb.sv
// testbench for the sorted list union and intersection block: random and directed commands
`timescale 1ns / 1ps

module sorted_set_union_intersection_top_tb;

    typedef struct {
        ssui_pkg::t_op                      op;
        logic signed [ssui_pkg::DATA_W-1:0] value;
        int unsigned                        idle_pct;
    } t_cmd;

    typedef struct {
        logic signed [ssui_pkg::DATA_W-1:0] value;
        ssui_pkg::t_status                  status;
        logic                               last;
    } t_word;

    localparam logic signed [ssui_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ssui_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int unsigned                        NUM_RANDOM = 420;

    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               start       = 1'b0;
    logic [1:0]                         i_operation = 2'd0;
    logic signed [ssui_pkg::DATA_W-1:0] i_value     = '0;
    logic                               busy;
    logic                               o_strobe;
    logic signed [ssui_pkg::DATA_W-1:0] o_result_value;
    logic [1:0]                         o_status;
    logic                               o_last;

    t_cmd                               cmd_queue[$];
    t_word                              words_due[$];
    logic signed [ssui_pkg::DATA_W-1:0] a_vals[ssui_pkg::CAPACITY];
    logic signed [ssui_pkg::DATA_W-1:0] b_vals[ssui_pkg::CAPACITY];
    int                                 a_len = 0;
    int                                 b_len = 0;
    int                                 err_count = 0;

    sorted_set_union_intersection_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_word(logic signed [ssui_pkg::DATA_W-1:0] v,
                                     ssui_pkg::t_status st, logic lst);
        words_due.push_back('{v, st, lst});
    endfunction

    // mark the final word of a readout, or give the empty status when there was none
    function automatic void close_readout(int n);
        t_word w;
        if (n == 0) begin
            add_word('0, ssui_pkg::ST_EMPTY, 1'b1);
        end else begin
            w = words_due.pop_back();
            w.last = 1'b1;
            words_due.push_back(w);
        end
    endfunction

    function automatic void predict_insert(bit to_b, logic signed [ssui_pkg::DATA_W-1:0] v);
        logic signed [ssui_pkg::DATA_W-1:0] vals[ssui_pkg::CAPACITY];
        int n;
        int pos;
        if (to_b) begin
            vals = b_vals;
            n    = b_len;
        end else begin
            vals = a_vals;
            n    = a_len;
        end
        if (n >= ssui_pkg::CAPACITY) begin
            add_word('0, ssui_pkg::ST_FULL, 1'b1);
            return;
        end
        pos = 0;
        while (pos < n && vals[pos] < v) pos++;
        for (int i = n; i > pos; i--) vals[i] = vals[i-1];
        vals[pos] = v;
        if (to_b) begin
            b_vals = vals;
            b_len  = n + 1;
        end else begin
            a_vals = vals;
            a_len  = n + 1;
        end
        add_word('0, ssui_pkg::ST_ACCEPT, 1'b1);
    endfunction

    function automatic void predict_union();
        int i;
        int j;
        int n;
        i = 0;
        j = 0;
        n = 0;
        while (i < a_len && j < b_len) begin
            if (a_vals[i] < b_vals[j]) begin
                add_word(a_vals[i], ssui_pkg::ST_ELEMENT, 1'b0);
                i++;
                n++;
            end else if (b_vals[j] < a_vals[i]) begin
                add_word(b_vals[j], ssui_pkg::ST_ELEMENT, 1'b0);
                j++;
                n++;
            end else begin
                j++;
            end
        end
        for (; i < a_len; i++, n++) add_word(a_vals[i], ssui_pkg::ST_ELEMENT, 1'b0);
        for (; j < b_len; j++, n++) add_word(b_vals[j], ssui_pkg::ST_ELEMENT, 1'b0);
        close_readout(n);
    endfunction

    function automatic void predict_intersection();
        int n;
        n = 0;
        for (int i = 0; i < a_len; i++)
            for (int j = 0; j < b_len; j++)
                if (a_vals[i] == b_vals[j]) begin
                    add_word(a_vals[i], ssui_pkg::ST_ELEMENT, 1'b0);
                    n++;
                end
        close_readout(n);
    endfunction

    function automatic logic signed [ssui_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4:       return 32'sd1;
            5:       return 32'sd5;
            6:       return -32'sd5;
            7:       return 32'sd7;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_cmd(ssui_pkg::t_op op, logic signed [ssui_pkg::DATA_W-1:0] v,
                                      int unsigned pct);
        cmd_queue.push_back('{op, v, pct});
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_cmd c;
        if (i_rst_n) begin
            if (start && !busy) begin
                case (ssui_pkg::t_op'(i_operation))
                    ssui_pkg::OP_INS_A: predict_insert(1'b0, i_value);
                    ssui_pkg::OP_INS_B: predict_insert(1'b1, i_value);
                    ssui_pkg::OP_UNION: predict_union();
                    default:            predict_intersection();
                endcase
            end
            if (!start || !busy) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
                    c = cmd_queue.pop_front();
                    start       <= 1'b1;
                    i_operation <= c.op;
                    i_value     <= c.value;
                end else begin
                    start       <= 1'b0;
                    i_operation <= 2'($urandom);
                    i_value     <= $urandom;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_strobe) begin
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word value %0d status %0d last %0b",
                         $time, o_result_value, o_status, o_last);
                err_count++;
            end else begin
                w = words_due.pop_front();
                if (o_result_value !== w.value || o_status !== w.status ||
                    o_last !== w.last) begin
                    $display({"%0t: mismatch exp value %0d status %0d last %0b, ",
                              "got value %0d status %0d last %0b"},
                             $time, w.value, w.status, w.last,
                             o_result_value, o_status, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int unsigned pct_table[4];
        pct_table = '{0, 78, 0, 12};
        // empty readouts, then one list only, then a shared value
        queue_cmd(ssui_pkg::OP_UNION, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INTER, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_UNION, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INTER, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INS_B, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_UNION, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INTER, 32'sd0, 0);
        // extremes and duplicates on both sides
        queue_cmd(ssui_pkg::OP_INS_A, VAL_MIN, 0);
        queue_cmd(ssui_pkg::OP_INS_A, VAL_MAX, 0);
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INS_B, VAL_MAX, 0);
        queue_cmd(ssui_pkg::OP_INS_B, VAL_MIN, 0);
        queue_cmd(ssui_pkg::OP_INS_B, -32'sd1, 0);
        queue_cmd(ssui_pkg::OP_INS_B, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_UNION, VAL_MAX, 0);
        queue_cmd(ssui_pkg::OP_INTER, VAL_MIN, 0);
        // fill list a, then overflow it
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd5, 0);
        queue_cmd(ssui_pkg::OP_INS_A, -32'sd5, 0);
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd7, 0);
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd7, 0);
        queue_cmd(ssui_pkg::OP_INS_A, 32'sd1, 0);
        queue_cmd(ssui_pkg::OP_UNION, 32'sd0, 0);
        queue_cmd(ssui_pkg::OP_INTER, 32'sd0, 0);
        for (int k = 0; k < NUM_RANDOM; k++)
            queue_cmd(ssui_pkg::t_op'($urandom_range(3)), pick_value(),
                      pct_table[(k / 60) % 4]);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || start || words_due.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (err_count == 0 && words_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d words outstanding", $time, words_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
